[hdl/gsr_pkg.sv]
// ----------------------------------------------------------------------------
// gsr_pkg: shared types and constants of the skin-response calibrator
// Range tables, fixed field widths and the header that one job carries
// from the front through the queue to the back.
// ----------------------------------------------------------------------------
package gsr_pkg;

  localparam int OUT_ADC_W = 12;   // width of the reported ADC value
  localparam int RES_W     = 21;   // resistance, kOhm in Q8
  localparam int CON_W     = 23;   // conductance, uS in Q16
  localparam int CON_NUM_W = 34;

  // 1000 * 2^16 * 2^8: conductance numerator against a Q8 resistance
  localparam logic [CON_NUM_W-1:0] CON_NUM = 34'd16777216000;

  // range_select after reset: auto range from the sample word
  localparam logic [2:0] RANGE_SEL_RESET = 3'd4;

  // resistance range codes
  localparam logic [1:0] RANGE_8K   = 2'd0;
  localparam logic [1:0] RANGE_63K  = 2'd1;
  localparam logic [1:0] RANGE_220K = 2'd2;
  localparam logic [1:0] RANGE_680K = 2'd3;

  typedef struct packed {
    logic [OUT_ADC_W-1:0] adc_value;
    logic [1:0]           rng;
    logic                 nonpos;    // 6*eff - F <= 0, eff = adc after range 3 floor
  } job_hdr_t;

  // reference resistor in tenths of a kOhm
  function automatic logic [15:0] rref10(input logic [1:0] rng);
    logic [15:0] r;
    unique case (rng)
      RANGE_8K:   r = 16'd402;
      RANGE_63K:  r = 16'd2870;
      RANGE_220K: r = 16'd10000;
      RANGE_680K: r = 16'd33000;
    endcase
    return r;
  endfunction

  function automatic logic [RES_W-1:0] r_min_q8(input logic [1:0] rng);
    logic [RES_W-1:0] r;
    unique case (rng)
      RANGE_8K:   r = 21'd2048;
      RANGE_63K:  r = 21'd16128;
      RANGE_220K: r = 21'd56320;
      RANGE_680K: r = 21'd174080;
    endcase
    return r;
  endfunction

  function automatic logic [RES_W-1:0] r_max_q8(input logic [1:0] rng);
    logic [RES_W-1:0] r;
    unique case (rng)
      RANGE_8K:   r = 21'd16128;
      RANGE_63K:  r = 21'd56320;
      RANGE_220K: r = 21'd174080;
      RANGE_680K: r = 21'd1203200;
    endcase
    return r;
  endfunction

endpackage

[hdl/gsr_front.sv]
// ----------------------------------------------------------------------------
// gsr_front: input stage
// Holds range_select, picks the range, applies the range 3 floor and
// forms the divider denominator 10*(6*adc - F). One registered job slot.
// ----------------------------------------------------------------------------
module gsr_front import gsr_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         raw_word_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output job_hdr_t            job_hdr_o,
  output logic [ADC_BITS+5:0] job_den_o
);

  localparam int SX_W = ADC_BITS + 3;
  localparam int D_W  = ADC_BITS + 6;
  localparam logic [ADC_BITS-1:0] ADC_FULL = '1;
  localparam logic [ADC_BITS-1:0] R3_FLOOR = ADC_BITS'(ADC_FULL / 6 + 1);

  logic [2:0]          range_sel_q;
  logic                v_q;
  job_hdr_t            hdr_q;
  logic [D_W-1:0]      den_q;

  logic                accept;
  logic [1:0]          rng;
  logic [ADC_BITS-1:0] adc;
  logic [ADC_BITS-1:0] eff;
  logic [SX_W-1:0]     six;
  logic [SX_W-1:0]     diff;
  job_hdr_t            hdr_d;
  logic [D_W-1:0]      den_d;

  assign in_ready_o = !v_q || job_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    // codes 4..7 all mean auto range
    rng   = range_sel_q[2] ? raw_word_i[15:14] : range_sel_q[1:0];
    adc   = raw_word_i[ADC_BITS-1:0];
    eff   = (rng == RANGE_680K && adc < R3_FLOOR) ? R3_FLOOR : adc;
    six   = SX_W'({eff, 2'b00}) + SX_W'({eff, 1'b0});
    diff  = six - SX_W'(ADC_FULL);
    den_d = {diff, 3'b000} + D_W'({diff, 1'b0});
    hdr_d.adc_value = OUT_ADC_W'(adc);
    hdr_d.rng       = rng;
    hdr_d.nonpos    = six <= SX_W'(ADC_FULL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_sel_q <= RANGE_SEL_RESET;
      v_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        range_sel_q <= cfg_wdata_i;
      end
      if (accept) begin
        v_q <= 1'b1;
      end else if (job_ready_i) begin
        v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hdr_q <= hdr_d;
      den_q <= den_d;
    end
  end

  assign job_valid_o = v_q;
  assign job_hdr_o   = hdr_q;
  assign job_den_o   = den_q;

endmodule

[hdl/gsr_fifo.sv]
// ----------------------------------------------------------------------------
// gsr_fifo: short job queue between front and back
// Register-based circular buffer with valid/ready on both sides.
// ----------------------------------------------------------------------------
module gsr_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q;
  logic [AW-1:0]    rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             push;
  logic             pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hdl/gsr_div.sv]
// ----------------------------------------------------------------------------
// gsr_div: pipelined restoring divider
// One quotient bit per stage, Q_W stages, common stall enable. Flags an
// overflow when the quotient does not fit in Q_W bits.
// ----------------------------------------------------------------------------
module gsr_div #(
  parameter int N_W = 34,
  parameter int D_W = 21,
  parameter int Q_W = 23,
  parameter int S_W = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           in_valid_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  input  logic [S_W-1:0] side_i,
  output logic           out_valid_o,
  output logic [Q_W-1:0] quot_o,
  output logic           ovf_o,
  output logic [S_W-1:0] side_o
);

  localparam int W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

  logic [Q_W-1:0] vld_q;
  logic [Q_W-1:0] ovf_q;
  logic [W-1:0]   rem_q  [Q_W];
  logic [D_W-1:0] den_q  [Q_W];
  logic [Q_W-1:0] quo_q  [Q_W];
  logic [S_W-1:0] side_q [Q_W];

  logic [Q_W-1:0] vld_src;
  logic [Q_W-1:0] ovf_src;
  logic [W-1:0]   rem_src  [Q_W];
  logic [D_W-1:0] den_src  [Q_W];
  logic [Q_W-1:0] quo_src  [Q_W];
  logic [S_W-1:0] side_src [Q_W];
  logic [W-1:0]   trial    [Q_W];
  logic [W-1:0]   rem_nx   [Q_W];
  logic [Q_W-1:0] quo_nx   [Q_W];
  logic [Q_W-1:0] ge;

  always_comb begin
    vld_src[0]  = in_valid_i;
    ovf_src[0]  = W'(num_i) >= (W'(den_i) << Q_W);
    rem_src[0]  = W'(num_i);
    den_src[0]  = den_i;
    quo_src[0]  = '0;
    side_src[0] = side_i;
    for (int i = 1; i < Q_W; i++) begin
      vld_src[i]  = vld_q[i-1];
      ovf_src[i]  = ovf_q[i-1];
      rem_src[i]  = rem_q[i-1];
      den_src[i]  = den_q[i-1];
      quo_src[i]  = quo_q[i-1];
      side_src[i] = side_q[i-1];
    end
    // stage i decides quotient bit Q_W-1-i
    for (int i = 0; i < Q_W; i++) begin
      trial[i]  = W'(den_src[i]) << (Q_W - 1 - i);
      ge[i]     = rem_src[i] >= trial[i];
      rem_nx[i] = ge[i] ? rem_src[i] - trial[i] : rem_src[i];
      quo_nx[i] = quo_src[i];
      quo_nx[i][Q_W-1-i] = ge[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_src;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q <= ovf_src;
      for (int i = 0; i < Q_W; i++) begin
        rem_q[i]  <= rem_nx[i];
        den_q[i]  <= den_src[i];
        quo_q[i]  <= quo_nx[i];
        side_q[i] <= side_src[i];
      end
    end
  end

  assign out_valid_o = vld_q[Q_W-1];
  assign quot_o      = quo_q[Q_W-1];
  assign ovf_o       = ovf_q[Q_W-1];
  assign side_o      = side_q[Q_W-1];

endmodule

[hdl/gsr_back.sv]
// ----------------------------------------------------------------------------
// gsr_back: calibration pipeline
// Resistance divider, range clamp, conductance divider and output
// register. The whole pipe advances while the output slot is empty or being taken.
// ----------------------------------------------------------------------------
module gsr_back import gsr_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  job_hdr_t             job_hdr_i,
  input  logic [ADC_BITS+5:0]  job_den_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_ADC_W-1:0] adc_value_o,
  output logic [1:0]           range_used_o,
  output logic [RES_W-1:0]     resistance_q8_o,
  output logic [CON_W-1:0]     conductance_q16_o
);

  localparam int D_W  = ADC_BITS + 6;
  localparam int N_W  = ADC_BITS + 24;
  localparam int S1_W = $bits(job_hdr_t);
  localparam int S2_W = OUT_ADC_W + 2 + RES_W;
  localparam longint unsigned FULL64 = (64'd1 << ADC_BITS) - 64'd1;
  // Rref10 * F * 256 per range; the 10 of the tenths sits in the denominator
  localparam logic [N_W-1:0] NUM_0 = N_W'(64'(rref10(RANGE_8K))   * FULL64 * 64'd256);
  localparam logic [N_W-1:0] NUM_1 = N_W'(64'(rref10(RANGE_63K))  * FULL64 * 64'd256);
  localparam logic [N_W-1:0] NUM_2 = N_W'(64'(rref10(RANGE_220K)) * FULL64 * 64'd256);
  localparam logic [N_W-1:0] NUM_3 = N_W'(64'(rref10(RANGE_680K)) * FULL64 * 64'd256);

  logic                 en;
  logic [N_W-1:0]       num_sel;

  logic                 d1_valid;
  logic [RES_W-1:0]     d1_quot;
  logic                 d1_ovf;
  logic [S1_W-1:0]      d1_side;
  job_hdr_t             d1_hdr;
  logic [RES_W-1:0]     lo;
  logic [RES_W-1:0]     hi;
  logic [RES_W-1:0]     res_d;

  logic                 cl_valid_q;
  logic [RES_W-1:0]     cl_res_q;
  logic [OUT_ADC_W-1:0] cl_adc_q;
  logic [1:0]           cl_rng_q;

  logic                 d2_valid;
  logic [CON_W-1:0]     d2_quot;
  logic                 d2_ovf;
  logic [S2_W-1:0]      d2_side;

  logic                 out_valid_q;
  logic [OUT_ADC_W-1:0] adc_q;
  logic [1:0]           rng_q;
  logic [RES_W-1:0]     res_q;
  logic [CON_W-1:0]     con_q;

  // stall-all pipe: move when the output slot is empty or being taken
  assign en          = !out_valid_q || out_ready_i;
  assign job_ready_o = en;

  always_comb begin
    unique case (job_hdr_i.rng)
      RANGE_8K:   num_sel = NUM_0;
      RANGE_63K:  num_sel = NUM_1;
      RANGE_220K: num_sel = NUM_2;
      RANGE_680K: num_sel = NUM_3;
    endcase
  end

  gsr_div #(
    .N_W (N_W),
    .D_W (D_W),
    .Q_W (RES_W),
    .S_W (S1_W)
  ) u_div_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (job_valid_i),
    .num_i       (num_sel),
    .den_i       (job_den_i),
    .side_i      (job_hdr_i),
    .out_valid_o (d1_valid),
    .quot_o      (d1_quot),
    .ovf_o       (d1_ovf),
    .side_o      (d1_side)
  );

  assign d1_hdr = d1_side;

  always_comb begin
    lo = r_min_q8(d1_hdr.rng);
    hi = r_max_q8(d1_hdr.rng);
    if (d1_hdr.nonpos) begin
      res_d = lo;
    end else if (d1_ovf || d1_quot > hi) begin
      res_d = hi;
    end else if (d1_quot < lo) begin
      res_d = lo;
    end else begin
      res_d = d1_quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      cl_valid_q  <= d1_valid;
      out_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cl_res_q <= res_d;
      cl_adc_q <= d1_hdr.adc_value;
      cl_rng_q <= d1_hdr.rng;
    end
  end

  gsr_div #(
    .N_W (CON_NUM_W),
    .D_W (RES_W),
    .Q_W (CON_W),
    .S_W (S2_W)
  ) u_div_con (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (cl_valid_q),
    .num_i       (CON_NUM),
    .den_i       (cl_res_q),
    .side_i      ({cl_adc_q, cl_rng_q, cl_res_q}),
    .out_valid_o (d2_valid),
    .quot_o      (d2_quot),
    .ovf_o       (d2_ovf),
    .side_o      (d2_side)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      {adc_q, rng_q, res_q} <= d2_side;
      con_q <= d2_quot;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign adc_value_o       = adc_q;
  assign range_used_o      = rng_q;
  assign resistance_q8_o   = res_q;
  assign conductance_q16_o = con_q;

`ifndef SYNTHESIS
  localparam int PW = CON_W + RES_W + 1;

  // divisor is at least the smallest range minimum, so no overflow
  a_con_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_valid |-> !d2_ovf)
    else $error("conductance divider overflow");

  a_res_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q >= r_min_q8(rng_q) && res_q <= r_max_q8(rng_q)))
    else $error("resistance outside range limits");

  a_con_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (PW'(con_q) * PW'(res_q) <= PW'(CON_NUM) &&
                     (PW'(con_q) + PW'(1)) * PW'(res_q) > PW'(CON_NUM)))
    else $error("conductance is not the truncated quotient");
`endif

endmodule

[hdl/gsr_resistance_calibrator_top.sv]
// ----------------------------------------------------------------------------
// gsr_resistance_calibrator_top: skin-response resistance calibrator
// Turns a sensor word into range, resistance (kOhm Q8) and conductance
// (uS Q16).
// ----------------------------------------------------------------------------
// Path of a beat: front slot, job queue, 21-stage resistance divider, clamp
//   register, 23-stage conductance divider (each divider retiring one quotient
//   bit a stage), output register. Throughput: one beat per cycle while not stalled.
// Output stall freezes the whole back pipe; the two-entry queue and the
//   front slot keep accepting until they fill.
// Reset (rst_ni low, async): all valid flags clear, range_select returns to 4.
module gsr_resistance_calibrator_top import gsr_pkg::*; #(
  parameter int ADC_BITS    = 12,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration: range_select, written when cfg_we_i is high
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_wdata_i,
  // sample beats
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [15:0]          raw_word_i,
  // result beats
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_ADC_W-1:0] adc_value_o,
  output logic [1:0]           range_used_o,
  output logic [RES_W-1:0]     resistance_q8_o,
  output logic [CON_W-1:0]     conductance_q16_o
);

  // denominator 10*(6*adc - F) stays below 64 * 2^ADC_BITS
  localparam int D_W = ADC_BITS + 6;
  localparam int Q_W = $bits(job_hdr_t) + D_W;

  // front -> queue
  logic           fr_valid;
  logic           fr_ready;
  job_hdr_t       fr_hdr;
  logic [D_W-1:0] fr_den;

  // queue -> back
  logic           bk_valid;
  logic           bk_ready;
  logic [Q_W-1:0] bk_data;
  job_hdr_t       bk_hdr;
  logic [D_W-1:0] bk_den;

  // Front: range selection, range 3 floor, denominator.
  gsr_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .raw_word_i  (raw_word_i),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_hdr_o   (fr_hdr),
    .job_den_o   (fr_den)
  );

  // Queue lets the front keep taking beats while the back is stalled.
  gsr_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  ({fr_hdr, fr_den}),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_data)
  );

  assign {bk_hdr, bk_den} = bk_data;

  // Back: both dividers, clamp and the output register.
  gsr_back #(
    .ADC_BITS (ADC_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_valid_i       (bk_valid),
    .job_ready_o       (bk_ready),
    .job_hdr_i         (bk_hdr),
    .job_den_i         (bk_den),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .adc_value_o       (adc_value_o),
    .range_used_o      (range_used_o),
    .resistance_q8_o   (resistance_q8_o),
    .conductance_q16_o (conductance_q16_o)
  );

endmodule
